// ===== hw/rtl/hsrt_pkg.sv =====
// shared types, constants and control structs for the hashed symbol reference table
package hsrt_pkg;

  localparam int TABLE_DEPTH = 128;
  // power of two, the bucket is taken from the low key bits
  localparam int BUCKETS     = 64;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int BKT_W = $clog2(BUCKETS);
  localparam int KEY_W = 32;
  localparam int REF_W = 8;
  localparam int ENT_W = KEY_W + IDX_W;

  typedef enum logic [2:0] {
    KIND_IDENT  = 3'd0,
    KIND_CONST  = 3'd1,
    KIND_STRING = 3'd2,
    KIND_LABEL  = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  localparam logic [1:0] SEEK_MAY  = 2'd0;
  localparam logic [1:0] SEEK_MUST = 2'd1;
  localparam logic [1:0] SEEK_NEW  = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_UNDEF = 2'd1;
  localparam logic [1:0] ERR_REDEF = 2'd2;
  localparam logic [1:0] ERR_OVF   = 2'd3;

  localparam logic [7:0] CH_CONST  = 8'h63;
  localparam logic [7:0] CH_LABEL  = 8'h6C;
  localparam logic [7:0] CH_GLOBAL = 8'h67;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_HEAD_LD,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_MISS,
    ST_INS_PREV,
    ST_ALLOC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic head_rd;
    logic head_ld;
    logic const_ld;
    logic entry_rd;
    logic walk_step;
    logic set_found;
    logic set_ovf;
    logic ins_new;
    logic ins_prev;
    logic alloc;
    logic clear;
    logic out_load;
  } hsrt_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  cur_zero;
    logic  key_eq;
    logic  key_gt;
    logic  prev_zero;
    logic  full;
    logic  out_free;
  } hsrt_sts_t;

endpackage

// ===== hw/rtl/hsrt_ram.sv =====
// generic simple dual port ram with registered read
module hsrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/hsrt_ctrl.sv =====
// sequencing state machine for lookup, insert and allocation
module hsrt_ctrl import hsrt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  hsrt_sts_t sts,
  output hsrt_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (sts.kind) inside
          KIND_IDENT:               state_nxt = ST_HEAD_LD;
          KIND_CONST:               state_nxt = ST_WALK_RD;
          KIND_STRING, KIND_LABEL:  state_nxt = ST_ALLOC;
          default:                  state_nxt = ST_DONE;
        endcase
      end
      ST_HEAD_LD: state_nxt = ST_WALK_RD;
      ST_WALK_RD: begin
        state_nxt = sts.cur_zero ? ST_MISS : ST_WALK_CMP;
      end
      ST_WALK_CMP: begin
        if (sts.key_eq) state_nxt = ST_DONE;
        else if (sts.key_gt) state_nxt = ST_MISS;
        else state_nxt = ST_WALK_RD;
      end
      ST_MISS: begin
        if (sts.full || sts.prev_zero) state_nxt = ST_DONE;
        else state_nxt = ST_INS_PREV;
      end
      ST_INS_PREV: state_nxt = ST_DONE;
      ST_ALLOC:    state_nxt = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_DISPATCH: begin
        unique case (sts.kind)
          KIND_IDENT: cmd.head_rd  = 1'b1;
          KIND_CONST: cmd.const_ld = 1'b1;
          KIND_CLEAR: cmd.clear    = 1'b1;
          default:    cmd.head_rd  = 1'b0;
        endcase
      end
      ST_HEAD_LD: cmd.head_ld = 1'b1;
      ST_WALK_RD: cmd.entry_rd = !sts.cur_zero;
      ST_WALK_CMP: begin
        cmd.set_found = sts.key_eq;
        cmd.walk_step = !sts.key_eq && !sts.key_gt;
      end
      ST_MISS: begin
        cmd.set_ovf = sts.full;
        cmd.ins_new = !sts.full;
      end
      ST_INS_PREV: cmd.ins_prev = 1'b1;
      ST_ALLOC: begin
        cmd.set_ovf = sts.full;
        cmd.alloc   = !sts.full;
      end
      ST_DONE: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

  // a compare always follows the entry read that feeds it
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK_CMP |-> $past(state_r) == ST_WALK_RD)
    else $error("compare without entry read");

  // a link patch only follows the insert of a new entry
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_INS_PREV |-> $past(state_r) == ST_MISS && !$past(sts.full))
    else $error("link patch without insert");

  // an allocation never happens while the table is full
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ins_new || cmd.alloc) |-> !sts.full)
    else $error("allocation on full table");

endmodule

// ===== hw/rtl/hsrt_dp.sv =====
// datapath: chain heads, entry store, allocator and result register
module hsrt_dp import hsrt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  hsrt_cmd_t               cmd,
  output hsrt_sts_t               sts,
  input  logic [2:0]              in_kind,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [7:0]              in_ident_type,
  input  logic [1:0]              in_seek_mode,
  input  logic                    in_in_param_list,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [REF_W-1:0]        out_ref_res,
  output logic                    out_is_new,
  output logic [1:0]              out_error,
  output logic                    out_emit,
  output logic [7:0]              out_emit_type,
  output logic                    out_emit_has_word,
  output logic signed [KEY_W-1:0] out_emit_word
);

  // transaction fields
  kind_t                   kind_r, kind_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [7:0]              type_r, type_nxt;
  logic [1:0]              seek_r, seek_nxt;
  logic                    plist_r, plist_nxt;

  // walk and result
  logic [IDX_W-1:0]        cur_r, cur_nxt;
  logic [IDX_W-1:0]        prev_r, prev_nxt;
  logic signed [KEY_W-1:0] prev_key_r, prev_key_nxt;
  logic [IDX_W-1:0]        res_idx_r, res_idx_nxt;
  logic                    is_new_r, is_new_nxt;
  logic [1:0]              err_r, err_nxt;

  // table control state
  logic [BUCKETS-1:0]      head_vld_r, head_vld_nxt;
  logic [IDX_W-1:0]        const_head_r, const_head_nxt;
  logic [CNT_W-1:0]        next_index_r, next_index_nxt;

  // result register
  logic                    out_valid_r, out_valid_nxt;
  logic [REF_W-1:0]        o_ref_r;
  logic                    o_new_r;
  logic [1:0]              o_err_r;
  logic                    o_emit_r;
  logic [7:0]              o_etype_r;
  logic                    o_hasw_r;
  logic signed [KEY_W-1:0] o_word_r;

  logic [BKT_W-1:0]        hash;
  logic [IDX_W-1:0]        new_idx;
  logic [IDX_W-1:0]        bkt_rdata;
  logic                    bkt_we;
  logic [ENT_W-1:0]        ent_rdata;
  logic [ENT_W-1:0]        ent_wdata;
  logic [IDX_W-1:0]        ent_waddr;
  logic                    ent_we;
  logic signed [KEY_W-1:0] ent_key;
  logic [IDX_W-1:0]        ent_link;
  logic                    out_free;
  logic                    emit_c;
  logic [7:0]              etype_c;
  logic                    hasw_c;

  assign hash     = key_r[BKT_W-1:0];
  assign new_idx  = next_index_r[IDX_W-1:0];
  assign ent_key  = ent_rdata[ENT_W-1:IDX_W];
  assign ent_link = ent_rdata[IDX_W-1:0];
  assign out_free = !out_valid_r || !out_stall;

  assign bkt_we    = cmd.ins_new && (prev_r == '0) && (kind_r == KIND_IDENT);
  assign ent_we    = cmd.ins_new || cmd.ins_prev;
  assign ent_waddr = cmd.ins_prev ? prev_r : new_idx;
  // new entry links to where the walk stopped; a patched entry links to the new one
  assign ent_wdata = cmd.ins_prev ? {prev_key_r, res_idx_r} : {key_r, cur_r};

  hsrt_ram #(.WIDTH(IDX_W), .DEPTH(BUCKETS)) u_bkt_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (hash),
    .wdata (new_idx),
    .re    (cmd.head_rd),
    .raddr (hash),
    .rdata (bkt_rdata)
  );

  hsrt_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (cmd.entry_rd),
    .raddr (cur_r),
    .rdata (ent_rdata)
  );

  always_comb begin
    sts.kind      = kind_r;
    sts.cur_zero  = (cur_r == '0);
    sts.key_eq    = (ent_key == key_r);
    sts.key_gt    = (ent_key > key_r);
    sts.prev_zero = (prev_r == '0);
    sts.full      = (next_index_r == CNT_W'(TABLE_DEPTH));
    sts.out_free  = out_free;
  end

  always_comb begin
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    type_nxt       = type_r;
    seek_nxt       = seek_r;
    plist_nxt      = plist_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    prev_key_nxt   = prev_key_r;
    res_idx_nxt    = res_idx_r;
    is_new_nxt     = is_new_r;
    err_nxt        = err_r;
    head_vld_nxt   = head_vld_r;
    const_head_nxt = const_head_r;
    next_index_nxt = next_index_r;

    if (cmd.accept) begin
      kind_nxt    = kind_t'(in_kind);
      key_nxt     = in_key;
      type_nxt    = in_ident_type;
      seek_nxt    = in_seek_mode;
      plist_nxt   = in_in_param_list;
      // inside a parameter list a required identifier becomes a local
      if (in_in_param_list && in_seek_mode == SEEK_MUST) begin
        seek_nxt = SEEK_MAY;
        type_nxt = CH_LABEL;
      end
      prev_nxt    = '0;
      res_idx_nxt = '0;
      is_new_nxt  = 1'b0;
      err_nxt     = ERR_NONE;
    end
    if (cmd.head_ld) begin
      cur_nxt = head_vld_r[hash] ? bkt_rdata : '0;
    end
    if (cmd.const_ld) begin
      cur_nxt = const_head_r;
    end
    if (cmd.walk_step) begin
      prev_nxt     = cur_r;
      prev_key_nxt = ent_key;
      cur_nxt      = ent_link;
    end
    if (cmd.set_found) begin
      res_idx_nxt = cur_r;
      if (kind_r == KIND_IDENT && seek_r == SEEK_NEW) err_nxt = ERR_REDEF;
    end
    if (cmd.set_ovf) begin
      err_nxt = ERR_OVF;
    end
    if (cmd.ins_new) begin
      res_idx_nxt    = new_idx;
      is_new_nxt     = 1'b1;
      next_index_nxt = next_index_r + CNT_W'(1);
      if (kind_r == KIND_IDENT && seek_r == SEEK_MUST) err_nxt = ERR_UNDEF;
      if (prev_r == '0) begin
        if (kind_r == KIND_IDENT) head_vld_nxt[hash] = 1'b1;
        else const_head_nxt = new_idx;
      end
    end
    if (cmd.alloc) begin
      res_idx_nxt    = new_idx;
      is_new_nxt     = 1'b1;
      next_index_nxt = next_index_r + CNT_W'(1);
    end
    if (cmd.clear) begin
      head_vld_nxt   = '0;
      const_head_nxt = '0;
      next_index_nxt = CNT_W'(1);
    end
  end

  always_comb begin
    emit_c  = 1'b0;
    etype_c = 8'h00;
    hasw_c  = 1'b0;
    case (kind_r)
      KIND_IDENT: begin
        emit_c  = is_new_r && (type_r != CH_LABEL);
        etype_c = type_r;
        hasw_c  = (type_r == CH_GLOBAL);
      end
      KIND_CONST: begin
        emit_c  = is_new_r;
        etype_c = CH_CONST;
        hasw_c  = 1'b1;
      end
      KIND_STRING: begin
        emit_c  = is_new_r;
        etype_c = plist_r ? CH_SQUOTE : CH_DQUOTE;
        hasw_c  = 1'b1;
      end
      default: emit_c = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r   <= '0;
      const_head_r <= '0;
      next_index_r <= CNT_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      head_vld_r   <= head_vld_nxt;
      const_head_r <= const_head_nxt;
      next_index_r <= next_index_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    key_r      <= key_nxt;
    type_r     <= type_nxt;
    seek_r     <= seek_nxt;
    plist_r    <= plist_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    prev_key_r <= prev_key_nxt;
    res_idx_r  <= res_idx_nxt;
    is_new_r   <= is_new_nxt;
    err_r      <= err_nxt;
    if (cmd.out_load) begin
      o_ref_r   <= REF_W'({res_idx_r, 1'b0});
      o_new_r   <= is_new_r;
      o_err_r   <= err_r;
      o_emit_r  <= emit_c;
      o_etype_r <= emit_c ? etype_c : 8'h00;
      o_hasw_r  <= emit_c && hasw_c;
      o_word_r  <= (emit_c && hasw_c) ? key_r : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ref_res       = o_ref_r;
  assign out_is_new        = o_new_r;
  assign out_error         = o_err_r;
  assign out_emit          = o_emit_r;
  assign out_emit_type     = o_etype_r;
  assign out_emit_has_word = o_hasw_r;
  assign out_emit_word     = o_word_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    next_index_r >= CNT_W'(1) && next_index_r <= CNT_W'(TABLE_DEPTH))
    else $error("allocator index out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_prev |-> prev_r != '0 && $past(cmd.ins_new))
    else $error("link patch without predecessor");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result not presented after load");

endmodule

// ===== hw/rtl/hashed_symbol_reference_table_core.sv =====
// top level of the hashed symbol reference table
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  kind, key, ident_type, seek_mode, in_param_list
//   out_     output     out_valid/out_stall  ref_res, is_new, error, emit, emit_type,
//                                            emit_has_word, emit_word
//
// one transaction at a time, walked state by state: an identifier passes dispatch, a bucket head
// load and then one entry ram read and compare per chain entry; a miss, stopped on a larger key
// or at the chain end, adds a miss state and, with a predecessor and a free entry, a link patch state
// a constant skips the bucket head load; string and label go through allocation, clear only dispatch
// synchronous reset empties all chains and restarts allocation at index 1, no clearing pass
// a waiting result sits in the output register while the next transaction is taken; that
// transaction holds in its last state until the register frees
module hashed_symbol_reference_table_core import hsrt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_kind,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [7:0]              in_ident_type,
  input  logic [1:0]              in_seek_mode,
  input  logic                    in_in_param_list,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [REF_W-1:0]        out_ref_res,
  output logic                    out_is_new,
  output logic [1:0]              out_error,
  output logic                    out_emit,
  output logic [7:0]              out_emit_type,
  output logic                    out_emit_has_word,
  output logic signed [KEY_W-1:0] out_emit_word
);

  hsrt_cmd_t cmd;
  hsrt_sts_t sts;

  hsrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hsrt_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_kind           (in_kind),
    .in_key            (in_key),
    .in_ident_type     (in_ident_type),
    .in_seek_mode      (in_seek_mode),
    .in_in_param_list  (in_in_param_list),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ref_res       (out_ref_res),
    .out_is_new        (out_is_new),
    .out_error         (out_error),
    .out_emit          (out_emit),
    .out_emit_type     (out_emit_type),
    .out_emit_has_word (out_emit_has_word),
    .out_emit_word     (out_emit_word)
  );

endmodule

// ===== tb/symbol_ref_checker.sv =====
// result checker for the symbol reference table: tracks table contents and compares results
`timescale 1ns / 1ps
module symbol_ref_checker import hsrt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [2:0]              in_kind,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [7:0]              in_ident_type,
  input  logic [1:0]              in_seek_mode,
  input  logic                    in_in_param_list,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [REF_W-1:0]        out_ref_res,
  input  logic                    out_is_new,
  input  logic [1:0]              out_error,
  input  logic                    out_emit,
  input  logic [7:0]              out_emit_type,
  input  logic                    out_emit_has_word,
  input  logic signed [KEY_W-1:0] out_emit_word,
  output int                      mismatches,
  output int                      pending
);

  typedef struct packed {
    logic [REF_W-1:0]        ref_res;
    logic                    is_new;
    logic [1:0]              error;
    logic                    emit;
    logic [7:0]              emit_type;
    logic                    emit_has_word;
    logic signed [KEY_W-1:0] emit_word;
  } sym_result_t;

  // shadow copy of the table
  logic [IDX_W-1:0]        bkt_head [BUCKETS];
  logic [IDX_W-1:0]        cst_head;
  logic [CNT_W-1:0]        alloc_ptr;
  logic signed [KEY_W-1:0] ent_key  [TABLE_DEPTH];
  logic [IDX_W-1:0]        ent_link [TABLE_DEPTH];

  sym_result_t expected_refs[$];
  int          fail_cnt = 0;
  int          result_no = 0;

  function automatic void clear_symbols();
    for (int b = 0; b < BUCKETS; b++) bkt_head[b] = '0;
    cst_head  = '0;
    alloc_ptr = CNT_W'(1);
  endfunction

  // walk a sorted chain; prev ends at the entry a new key goes after (0 = head)
  function automatic logic [IDX_W-1:0] seek_chain(input logic [IDX_W-1:0] head,
                                                  input logic signed [KEY_W-1:0] key,
                                                  output logic [IDX_W-1:0] prev);
    logic [IDX_W-1:0] cur;
    logic [IDX_W-1:0] hit;
    int               steps;
    cur   = head;
    prev  = '0;
    hit   = '0;
    steps = 0;
    while (cur != 0 && hit == 0 && steps < TABLE_DEPTH) begin
      if (ent_key[cur] == key) begin
        hit = cur;
      end else if (ent_key[cur] > key) begin
        cur = '0;
      end else begin
        prev  = cur;
        cur   = ent_link[cur];
        steps++;
      end
    end
    return hit;
  endfunction

  function automatic logic [IDX_W-1:0] take_entry(input logic signed [KEY_W-1:0] key);
    logic [IDX_W-1:0] idx;
    idx           = alloc_ptr[IDX_W-1:0];
    ent_key[idx]  = key;
    ent_link[idx] = '0;
    alloc_ptr     = alloc_ptr + 1'b1;
    return idx;
  endfunction

  function automatic logic [IDX_W-1:0] insert_sorted(input logic to_const,
                                                     input logic [BKT_W-1:0] bkt,
                                                     input logic [IDX_W-1:0] prev,
                                                     input logic signed [KEY_W-1:0] key);
    logic [IDX_W-1:0] idx;
    idx = take_entry(key);
    if (prev != 0) begin
      ent_link[idx]  = ent_link[prev];
      ent_link[prev] = idx;
    end else if (to_const) begin
      ent_link[idx] = cst_head;
      cst_head      = idx;
    end else begin
      ent_link[idx] = bkt_head[bkt];
      bkt_head[bkt] = idx;
    end
    return idx;
  endfunction

  function automatic sym_result_t resolve_symbol(input logic [2:0] kind,
                                                 input logic signed [KEY_W-1:0] key,
                                                 input logic [7:0] itype,
                                                 input logic [1:0] seek,
                                                 input logic plist);
    sym_result_t      r;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] prev;
    logic [BKT_W-1:0] bkt;
    logic [1:0]       mode;
    logic [7:0]       ty;
    logic             full;
    r    = '0;
    idx  = '0;
    mode = seek;
    ty   = itype;
    bkt  = key[BKT_W-1:0];
    full = alloc_ptr >= TABLE_DEPTH;
    case (kind)
      KIND_IDENT: begin
        // inside a parameter list a required identifier becomes a local
        if (plist && mode == SEEK_MUST) begin
          mode = SEEK_MAY;
          ty   = CH_LABEL;
        end
        idx = seek_chain(bkt_head[bkt], key, prev);
        if (idx == 0) begin
          if (full) begin
            r.error = ERR_OVF;
          end else begin
            if (mode == SEEK_MUST) r.error = ERR_UNDEF;
            idx      = insert_sorted(1'b0, bkt, prev, key);
            r.is_new = 1'b1;
            if (ty != CH_LABEL) begin
              r.emit      = 1'b1;
              r.emit_type = ty;
              if (ty == CH_GLOBAL) begin
                r.emit_has_word = 1'b1;
                r.emit_word     = key;
              end
            end
          end
        end else if (mode == SEEK_NEW) begin
          r.error = ERR_REDEF;
        end
      end
      KIND_CONST: begin
        idx = seek_chain(cst_head, key, prev);
        if (idx == 0) begin
          if (full) begin
            r.error = ERR_OVF;
          end else begin
            idx             = insert_sorted(1'b1, bkt, prev, key);
            r.is_new        = 1'b1;
            r.emit          = 1'b1;
            r.emit_type     = CH_CONST;
            r.emit_has_word = 1'b1;
            r.emit_word     = key;
          end
        end
      end
      KIND_STRING: begin
        if (full) begin
          r.error = ERR_OVF;
        end else begin
          idx             = take_entry(key);
          r.is_new        = 1'b1;
          r.emit          = 1'b1;
          r.emit_type     = plist ? CH_SQUOTE : CH_DQUOTE;
          r.emit_has_word = 1'b1;
          r.emit_word     = key;
        end
      end
      KIND_LABEL: begin
        if (full) begin
          r.error = ERR_OVF;
        end else begin
          idx      = take_entry('0);
          r.is_new = 1'b1;
        end
      end
      KIND_CLEAR: clear_symbols();
      default: ;
    endcase
    r.ref_res = {idx, 1'b0};
    return r;
  endfunction

  always @(posedge clk) begin : track
    sym_result_t want;
    sym_result_t got;
    if (!rst_n) begin
      clear_symbols();
      expected_refs.delete();
      mismatches <= 0;
      pending    <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_refs.push_back(resolve_symbol(in_kind, in_key, in_ident_type,
                                               in_seek_mode, in_in_param_list));
      end
      if (out_valid && !out_stall) begin
        got = {out_ref_res, out_is_new, out_error, out_emit, out_emit_type,
               out_emit_has_word, out_emit_word};
        result_no++;
        if (expected_refs.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("result %0d: no transaction outstanding", result_no);
        end else begin
          want = expected_refs.pop_front();
          if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("result %0d exp: ref=%0d new=%b err=%0d emit=%b type=%h word=%b/%0d",
                       result_no, want.ref_res, want.is_new, want.error, want.emit,
                       want.emit_type, want.emit_has_word, want.emit_word);
              $display("result %0d got: ref=%0d new=%b err=%0d emit=%b type=%h word=%b/%0d",
                       result_no, got.ref_res, got.is_new, got.error, got.emit,
                       got.emit_type, got.emit_has_word, got.emit_word);
            end
          end
        end
      end
      mismatches <= fail_cnt;
      pending    <= expected_refs.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// top of the symbol reference table testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
  import hsrt_pkg::*;

  localparam int         CYCLE_LIMIT     = 1000000;
  localparam int         RANDOM_ITEMS    = 800;
  localparam int         DRAIN_CYCLES    = 300;
  localparam logic [2:0] KIND_RSVD_FIRST = 3'd5;
  localparam logic [1:0] SEEK_SPARE      = 2'd3;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [2:0]              in_kind = '0;
  logic signed [KEY_W-1:0] in_key = '0;
  logic [7:0]              in_ident_type = '0;
  logic [1:0]              in_seek_mode = '0;
  logic                    in_in_param_list = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [REF_W-1:0]        out_ref_res;
  logic                    out_is_new;
  logic [1:0]              out_error;
  logic                    out_emit;
  logic [7:0]              out_emit_type;
  logic                    out_emit_has_word;
  logic signed [KEY_W-1:0] out_emit_word;

  int mismatches;
  int pending;
  int cycle_cnt = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_hold = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hashed_symbol_reference_table_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_key            (in_key),
    .in_ident_type     (in_ident_type),
    .in_seek_mode      (in_seek_mode),
    .in_in_param_list  (in_in_param_list),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ref_res       (out_ref_res),
    .out_is_new        (out_is_new),
    .out_error         (out_error),
    .out_emit          (out_emit),
    .out_emit_type     (out_emit_type),
    .out_emit_has_word (out_emit_has_word),
    .out_emit_word     (out_emit_word)
  );

  symbol_ref_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_key            (in_key),
    .in_ident_type     (in_ident_type),
    .in_seek_mode      (in_seek_mode),
    .in_in_param_list  (in_in_param_list),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ref_res       (out_ref_res),
    .out_is_new        (out_is_new),
    .out_error         (out_error),
    .out_emit          (out_emit),
    .out_emit_type     (out_emit_type),
    .out_emit_has_word (out_emit_has_word),
    .out_emit_word     (out_emit_word),
    .mismatches        (mismatches),
    .pending           (pending)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: free running, random, or mostly stalled, switching modes at random times
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_hold <= $urandom_range(50, 400);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // returns just after the edge that accepted the transaction
  task automatic put_txn(input logic [2:0] kind, input logic signed [KEY_W-1:0] key,
                         input logic [7:0] itype, input logic [1:0] seek,
                         input logic plist);
    int idle;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (idle > 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_key           <= key;
    in_ident_type    <= itype;
    in_seek_mode     <= seek;
    in_in_param_list <= plist;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic put_random(output logic counted);
    int                      pick;
    logic [2:0]              kind;
    logic signed [KEY_W-1:0] key;
    logic [7:0]              itype;
    pick = $urandom_range(0, 99);
    if (pick < 50)      kind = KIND_IDENT;
    else if (pick < 70) kind = KIND_CONST;
    else if (pick < 83) kind = KIND_STRING;
    else if (pick < 96) kind = KIND_LABEL;
    else                kind = KIND_RSVD_FIRST + 3'($urandom_range(0, 2));
    // mostly a few hot buckets with small names so that lookups hit and chains grow
    case ($urandom_range(0, 3))
      0:       key = $urandom;
      1, 2:    key = (int'($urandom_range(0, 15)) - 8) * 64 + int'($urandom_range(0, 3));
      default: begin
        case ($urandom_range(0, 3))
          0:       key = 32'sh7fffffff;
          1:       key = 32'sh80000000;
          2:       key = '0;
          default: key = -1;
        endcase
      end
    endcase
    case ($urandom_range(0, 3))
      0:       itype = CH_GLOBAL;
      1:       itype = CH_LABEL;
      2:       itype = CH_CONST;
      default: itype = 8'($urandom);
    endcase
    put_txn(kind, key, itype, 2'($urandom_range(0, 3)), ($urandom_range(0, 3) == 0));
    counted = (kind <= KIND_LABEL);
  endtask

  initial begin : stimulus
    int   sent;
    int   ep_len;
    logic counted;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // chain order, seek modes and parameter list handling
    put_txn(KIND_IDENT, 0, CH_GLOBAL, SEEK_MAY, 1'b0);
    put_txn(KIND_IDENT, 0, CH_GLOBAL, SEEK_NEW, 1'b0);
    put_txn(KIND_IDENT, 64, 8'h78, SEEK_MUST, 1'b0);
    put_txn(KIND_IDENT, -64, CH_LABEL, SEEK_MAY, 1'b0);
    put_txn(KIND_IDENT, 32, CH_GLOBAL, SEEK_NEW, 1'b0);
    put_txn(KIND_IDENT, 32'sh7fffffff, 8'hff, SEEK_MAY, 1'b0);
    put_txn(KIND_IDENT, 32'sh80000000, CH_GLOBAL, SEEK_MUST, 1'b1);
    put_txn(KIND_IDENT, 64, 8'h00, SEEK_SPARE, 1'b0);
    put_txn(KIND_IDENT, 32, CH_GLOBAL, SEEK_MUST, 1'b1);
    put_txn(KIND_CONST, 5, 8'h00, SEEK_MAY, 1'b0);
    put_txn(KIND_CONST, -5, 8'hff, SEEK_NEW, 1'b1);
    put_txn(KIND_CONST, 5, 8'h00, SEEK_MUST, 1'b0);
    put_txn(KIND_CONST, 32'sh7fffffff, 8'h00, SEEK_MAY, 1'b0);
    put_txn(KIND_CONST, 32'sh80000000, 8'h00, SEEK_MAY, 1'b0);
    put_txn(KIND_STRING, -1, 8'h00, SEEK_MAY, 1'b0);
    put_txn(KIND_STRING, 32'sh7fffffff, 8'hff, SEEK_MUST, 1'b1);
    put_txn(KIND_LABEL, $urandom, 8'($urandom), SEEK_MAY, 1'b0);
    for (int j = 0; j < 3; j++) begin
      put_txn(KIND_RSVD_FIRST + 3'(j), $urandom, 8'($urandom), 2'($urandom), 1'($urandom));
    end
    put_txn(KIND_CLEAR, $urandom, 8'($urandom), 2'($urandom), 1'($urandom));
    put_txn(KIND_IDENT, 0, CH_GLOBAL, SEEK_NEW, 1'b0);
    put_txn(KIND_CONST, 5, 8'h00, SEEK_MAY, 1'b0);

    // episodes between clears; the long ones run the table into overflow
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      ep_len = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 320) : $urandom_range(10, 80);
      for (int i = 0; i < ep_len && sent < RANDOM_ITEMS; i++) begin
        put_random(counted);
        if (counted) sent++;
      end
      put_txn(KIND_CLEAR, $urandom, 8'($urandom), 2'($urandom), 1'($urandom));
    end
    in_valid <= 1'b0;

    // wait for the checker's outstanding count to take in the last transaction
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/hsrt_pkg.sv
hw/rtl/hsrt_ram.sv
hw/rtl/hsrt_ctrl.sv
hw/rtl/hsrt_dp.sv
hw/rtl/hashed_symbol_reference_table_core.sv
tb/symbol_ref_checker.sv
tb/testbench.sv
